### rtl/core/ihp_pkg.sv
// Shared constants for the indexed min-heap: field widths, codes and defaults.
package ihp_pkg;

  localparam int KEY_W = 6;
  localparam int IN_VALUE_W = 32;
  localparam int STATUS_W = 2;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

### rtl/core/indexed_min_heap.sv
// Indexed binary min-heap with key-to-position map and a sequenced sift engine.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | action, key, value
//   out     | output    | out_valid / out_stall | status, out_key, out_value
//
// Insert: reads the key's map entry and, for an update, its slot; sifts up, then down, and
// writes the item into its final slot. Delete-min reads the root and the last slot and sifts
// the last item down from the root, or ends at once if the heap empties. No new item is taken
// until the last result is on the output; one read port and one comparator set this.
// Reset clears only the state, count and out_valid; a map entry is trusted only if it points
// below the count at a slot with the same key. A waiting result holds the next item in its last state.
module indexed_min_heap #(
  parameter int CAPACITY = ihp_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ihp_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                action,
  input  logic [ihp_pkg::KEY_W-1:0]           key,
  input  logic signed [ihp_pkg::IN_VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ihp_pkg::STATUS_W-1:0]        status,
  output logic [ihp_pkg::KEY_W-1:0]           out_key,
  output logic signed [ihp_pkg::IN_VALUE_W-1:0] out_value
);

  // Keys are six bits wide, so no more than 64 slots can ever be occupied.
  localparam int SLOTS = (CAPACITY < 64) ? CAPACITY : 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int KW = ihp_pkg::KEY_W;
  localparam int OW = ihp_pkg::IN_VALUE_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_POS   = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_UP    = 4'd4;
  localparam logic [3:0] S_UPCMP = 4'd5;
  localparam logic [3:0] S_DOWN  = 4'd6;
  localparam logic [3:0] S_DL    = 4'd7;
  localparam logic [3:0] S_DR    = 4'd8;
  localparam logic [3:0] S_DCMP  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_DEL0  = 4'd11;
  localparam logic [3:0] S_DEL1  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0] state;
  logic [CNT_W-1:0] count;
  logic act;
  logic [KW-1:0] mkey;
  logic [VALUE_BITS-1:0] mval;
  logic [SLOT_W-1:0] hole;
  logic [SLOT_W-1:0] child;
  logic [KW-1:0] best_key;
  logic [VALUE_BITS-1:0] best_val;
  logic [SLOT_W-1:0] best_idx;
  logic [ihp_pkg::STATUS_W-1:0] res_status;
  logic [KW-1:0] res_key;
  logic [OW-1:0] res_val;

  logic [KW-1:0] heap_keys [SLOTS];
  logic [VALUE_BITS-1:0] heap_vals [SLOTS];
  logic [SLOT_W-1:0] pos_mem [SLOTS];
  logic [KW-1:0] key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [SLOT_W-1:0] pos_q;

  logic rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic we;
  logic [SLOT_W-1:0] wr_addr;
  logic [KW-1:0] wr_key;
  logic [VALUE_BITS-1:0] wr_val;

  logic [VALUE_BITS-1:0] cmp_a;
  logic [VALUE_BITS-1:0] cmp_b;
  logic cmp_lt;

  logic in_take;
  logic out_free;
  logic [63:0] value_wide;
  logic [63:0] root_ext;
  logic [CNT_W:0] left_idx;
  logic [CNT_W:0] right_idx;
  logic [SLOT_W-1:0] parent;
  logic [CNT_W-1:0] count_dec;
  logic pos_live;

  assign in_stall = (state != S_IDLE);
  assign in_take = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign value_wide = 64'($unsigned(value));
  assign root_ext = 64'($signed(val_q));
  assign left_idx = (CNT_W + 1)'({hole, 1'b1});
  assign right_idx = (CNT_W + 1)'(child) + (CNT_W + 1)'(1);
  assign parent = SLOT_W'((hole - SLOT_W'(1)) >> 1);
  assign count_dec = count - CNT_W'(1);
  assign pos_live = (CNT_W'(pos_q) < count);
  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

  // Memory port control and the shared comparator's operands.
  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    we = 1'b0;
    wr_addr = hole;
    wr_key = mkey;
    wr_val = mval;
    cmp_a = mval;
    cmp_b = val_q;
    case (state)
      S_START: begin
        rd_en = (act == ihp_pkg::ACT_DELETE);
        rd_addr = '0;
      end
      S_POS: begin
        rd_en = pos_live;
        rd_addr = pos_q;
      end
      S_UP: begin
        rd_en = (hole != '0);
        rd_addr = parent;
      end
      S_UPCMP: begin
        we = cmp_lt;
        wr_key = key_q;
        wr_val = val_q;
      end
      S_DOWN: begin
        rd_en = (left_idx < (CNT_W + 1)'(count));
        rd_addr = left_idx[SLOT_W-1:0];
      end
      S_DL: begin
        rd_en = (right_idx < (CNT_W + 1)'(count));
        rd_addr = right_idx[SLOT_W-1:0];
      end
      S_DR: begin
        cmp_a = val_q;
        cmp_b = best_val;
      end
      S_DCMP: begin
        cmp_a = best_val;
        cmp_b = mval;
        we = cmp_lt;
        wr_key = best_key;
        wr_val = best_val;
      end
      S_FIN: begin
        we = 1'b1;
      end
      S_DEL0: begin
        rd_en = (count_dec != '0);
        rd_addr = count_dec[SLOT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      key_q <= heap_keys[rd_addr];
      val_q <= heap_vals[rd_addr];
    end
    if (we) begin
      heap_keys[wr_addr] <= wr_key;
      heap_vals[wr_addr] <= wr_val;
      pos_mem[wr_key[SLOT_W-1:0]] <= wr_addr;
    end
    if (state == S_START) begin
      pos_q <= pos_mem[mkey[SLOT_W-1:0]];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            act <= action;
            mkey <= key;
            mval <= value_wide[VALUE_BITS-1:0];
            if (action == ihp_pkg::ACT_DELETE && count == '0) begin
              res_status <= ihp_pkg::ST_EMPTY;
              res_key <= '0;
              res_val <= '0;
              state <= S_DONE;
            end else if (action == ihp_pkg::ACT_INSERT && 32'(key) >= CAPACITY) begin
              res_status <= ihp_pkg::ST_RANGE;
              res_key <= key;
              res_val <= value;
              state <= S_DONE;
            end else begin
              res_status <= ihp_pkg::ST_OK;
              res_key <= key;
              res_val <= value;
              state <= S_START;
            end
          end
        end
        S_START: begin
          state <= (act == ihp_pkg::ACT_DELETE) ? S_DEL0 : S_POS;
        end
        S_POS: begin
          if (pos_live) begin
            state <= S_CHK;
          end else begin
            hole <= count[SLOT_W-1:0];
            count <= count + CNT_W'(1);
            state <= S_UP;
          end
        end
        S_CHK: begin
          if (key_q == mkey) begin
            hole <= pos_q;
          end else begin
            hole <= count[SLOT_W-1:0];
            count <= count + CNT_W'(1);
          end
          state <= S_UP;
        end
        S_UP: begin
          state <= (hole != '0) ? S_UPCMP : S_DOWN;
        end
        S_UPCMP: begin
          if (cmp_lt) begin
            hole <= parent;
            state <= S_UP;
          end else begin
            state <= S_DOWN;
          end
        end
        S_DOWN: begin
          if (left_idx < (CNT_W + 1)'(count)) begin
            child <= left_idx[SLOT_W-1:0];
            state <= S_DL;
          end else begin
            state <= S_FIN;
          end
        end
        S_DL: begin
          best_key <= key_q;
          best_val <= val_q;
          best_idx <= child;
          state <= (right_idx < (CNT_W + 1)'(count)) ? S_DR : S_DCMP;
        end
        S_DR: begin
          // The right child wins only when strictly smaller.
          if (cmp_lt) begin
            best_key <= key_q;
            best_val <= val_q;
            best_idx <= right_idx[SLOT_W-1:0];
          end
          state <= S_DCMP;
        end
        S_DCMP: begin
          if (cmp_lt) begin
            hole <= best_idx;
            state <= S_DOWN;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_DONE;
        end
        S_DEL0: begin
          res_key <= key_q;
          res_val <= root_ext[OW-1:0];
          count <= count_dec;
          state <= (count_dec != '0) ? S_DEL1 : S_DONE;
        end
        S_DEL1: begin
          mkey <= key_q;
          mval <= val_q;
          hole <= '0;
          state <= S_DOWN;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status <= res_status;
            out_key <= res_key;
            out_value <= res_val;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SLOTS))
    else $error("entry count exceeds the slot count");

  a_write_in_heap: assert property (@(posedge clk) disable iff (rst)
    we |-> (CNT_W'(hole) < count))
    else $error("heap write outside the occupied slots");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + CNT_W'(1) ||
                     count == $past(count) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the finishing state");

endmodule

### sim/indexed_min_heap_tb.sv
// Self-checking testbench for the indexed min-heap: a queue-fed driver, a monitor and a predictor.
`timescale 1ns / 1ps

module indexed_min_heap_tb;

  localparam int CAPACITY = ihp_pkg::CAPACITY_DEF;
  localparam int KEY_W = ihp_pkg::KEY_W;
  localparam int IN_VALUE_W = ihp_pkg::IN_VALUE_W;
  localparam int STATUS_W = ihp_pkg::STATUS_W;
  localparam int REQ_TOTAL = 1850;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_AT_RESULT = 500;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic                         act;
    logic [KEY_W-1:0]             k;
    logic signed [IN_VALUE_W-1:0] v;
    bit                           drain_first;
  } heap_req_t;

  typedef struct {
    logic [STATUS_W-1:0]          st;
    logic [KEY_W-1:0]             k;
    logic signed [IN_VALUE_W-1:0] v;
  } heap_resp_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         action = ihp_pkg::ACT_INSERT;
  logic [KEY_W-1:0]             key = '0;
  logic signed [IN_VALUE_W-1:0] value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [STATUS_W-1:0]          status;
  logic [KEY_W-1:0]             out_key;
  logic signed [IN_VALUE_W-1:0] out_value;

  heap_req_t  pending_reqs[$];
  heap_resp_t expected_resps[$];

  // Shadow copy of the heap.
  logic [KEY_W-1:0]             slot_key[CAPACITY];
  logic signed [IN_VALUE_W-1:0] slot_val[CAPACITY];
  int                           key_slot[CAPACITY];
  int                           heap_size;

  int fails = 0;
  int cycle_count = 0;
  int send_gap, send_ticks;
  int recv_gap, recv_ticks, hold_left, results_seen;

  indexed_min_heap u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .key       (key),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .out_key   (out_key),
    .out_value (out_value)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function void clear_heap();
    heap_size = 0;
    for (int i = 0; i < CAPACITY; i++) key_slot[i] = CAPACITY;
  endfunction

  function void swap_slots(int a, int b);
    logic [KEY_W-1:0]             tk;
    logic signed [IN_VALUE_W-1:0] tv;
    tk = slot_key[a];
    tv = slot_val[a];
    slot_key[a] = slot_key[b];
    slot_val[a] = slot_val[b];
    slot_key[b] = tk;
    slot_val[b] = tv;
    key_slot[slot_key[a]] = a;
    key_slot[slot_key[b]] = b;
  endfunction

  function int rise(int n);
    int p;
    while (n > 0) begin
      p = (n - 1) / 2;
      if (!(slot_val[n] < slot_val[p])) break;
      swap_slots(n, p);
      n = p;
    end
    return n;
  endfunction

  // Ties go to the left child; stop once the smaller child is not below the entry.
  function void sink(int n);
    int c;
    while (2 * n + 1 < heap_size) begin
      c = 2 * n + 1;
      if (c + 1 < heap_size && slot_val[c + 1] < slot_val[c]) c = c + 1;
      if (!(slot_val[c] < slot_val[n])) break;
      swap_slots(n, c);
      n = c;
    end
  endfunction

  function void predict_heap_op(logic act, logic [KEY_W-1:0] k,
                                logic signed [IN_VALUE_W-1:0] v);
    heap_resp_t r;
    int         n;
    if (act == ihp_pkg::ACT_DELETE) begin
      if (heap_size == 0) begin
        r = '{ihp_pkg::ST_EMPTY, '0, '0};
      end else begin
        r = '{ihp_pkg::ST_OK, slot_key[0], slot_val[0]};
        key_slot[slot_key[0]] = CAPACITY;
        heap_size--;
        if (heap_size > 0) begin
          slot_key[0] = slot_key[heap_size];
          slot_val[0] = slot_val[heap_size];
          key_slot[slot_key[0]] = 0;
          sink(0);
        end
      end
    end else if (int'(k) >= CAPACITY) begin
      r = '{ihp_pkg::ST_RANGE, k, v};
    end else begin
      n = key_slot[k];
      if (n >= heap_size) begin
        n = heap_size;
        heap_size++;
        key_slot[k] = n;
      end
      slot_key[n] = k;
      slot_val[n] = v;
      n = rise(n);
      sink(n);
      r = '{ihp_pkg::ST_OK, k, v};
    end
    expected_resps.push_back(r);
  endfunction

  function int draw_gap();
    int r;
    r = $urandom_range(15);
    if (r < 9) return 0;
    if (r < 15) return $urandom_range(1, 3);
    return $urandom_range(20, 40);
  endfunction

  // A narrow band produces many ties; extremes and full-range values cover every bit.
  function logic signed [IN_VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh0000_0000;
        default: return 32'shFFFF_FFFF;
      endcase
    end
    if (r < 5) return IN_VALUE_W'(int'($urandom_range(16)) - 8);
    return $urandom;
  endfunction

  function void add_req(logic act, logic [KEY_W-1:0] k, logic signed [IN_VALUE_W-1:0] v,
                        bit drain_first);
    heap_req_t q;
    q.act = act;
    q.k = k;
    q.v = v;
    q.drain_first = drain_first;
    pending_reqs.push_back(q);
  endfunction

  // Driver: presents queued items and holds each one until it is taken.
  always @(posedge clk) begin : driver
    bit        offering;
    heap_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      clear_heap();
      send_gap = 0;
      send_ticks = 0;
    end else begin
      send_ticks++;
      offering = in_valid;
      if (in_valid && !in_stall) begin
        predict_heap_op(action, key, value);
        offering = 1'b0;
        send_gap = (send_ticks % 2048 < 512) ? 0 : draw_gap();
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].drain_first || expected_resps.size() == 0)) begin
          nxt = pending_reqs.pop_front();
          in_valid <= 1'b1;
          action <= nxt.act;
          key <= nxt.k;
          value <= nxt.v;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each taken result and drives the output stall.
  always @(posedge clk) begin : monitor
    heap_resp_t want;
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap = 0;
      recv_ticks = 0;
      hold_left = 0;
      results_seen = 0;
    end else begin
      recv_ticks++;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_resps.size() == 0) begin
          $error("unexpected result: status %0d out_key %0d out_value %0d",
                 status, out_key, out_value);
          fails++;
        end else begin
          want = expected_resps.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            fails++;
          end
          if (out_key !== want.k) begin
            $error("out_key: expected %0d, got %0d", want.k, out_key);
            fails++;
          end
          if (out_value !== want.v) begin
            $error("out_value: expected %0d, got %0d", want.v, out_value);
            fails++;
          end
        end
        // One long hold-off so the block backs up and stalls its input.
        if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (recv_gap == 0 && recv_ticks % 1536 >= 384) recv_gap = draw_gap();
        if (recv_gap > 0) begin
          recv_gap--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int  total, phase_left, ins_pct;
    logic act;

    // Directed part: empty delete, extreme values and keys, ties, updates both ways.
    add_req(ihp_pkg::ACT_DELETE, 6'd63, 32'sh1234_5678, 1'b0);
    add_req(ihp_pkg::ACT_INSERT, 6'd0, 32'sh7FFF_FFFF, 1'b0);
    add_req(ihp_pkg::ACT_INSERT, 6'd63, 32'sh8000_0000, 1'b0);
    add_req(ihp_pkg::ACT_INSERT, 6'd5, 32'sh0000_0000, 1'b0);
    add_req(ihp_pkg::ACT_INSERT, 6'd10, 32'shFFFF_FFFF, 1'b0);
    add_req(ihp_pkg::ACT_INSERT, 6'd20, 32'shFFFF_FFFF, 1'b0);
    add_req(ihp_pkg::ACT_INSERT, 6'd42, 32'sh5555_5555, 1'b0);
    add_req(ihp_pkg::ACT_INSERT, 6'd21, 32'shAAAA_AAAA, 1'b0);
    add_req(ihp_pkg::ACT_INSERT, 6'd0, 32'sh8000_0001, 1'b0);
    add_req(ihp_pkg::ACT_INSERT, 6'd63, 32'sh7FFF_FFFF, 1'b0);
    add_req(ihp_pkg::ACT_INSERT, 6'd5, 32'shFFFF_FFFF, 1'b0);
    for (int i = 0; i < 8; i++) begin
      add_req(ihp_pkg::ACT_DELETE, KEY_W'($urandom), $urandom, 1'b0);
    end
    add_req(ihp_pkg::ACT_DELETE, 6'd0, 32'sh0000_0000, 1'b0);

    // Random part: phases that grow, drain or churn the heap.
    total = 0;
    phase_left = 0;
    ins_pct = 50;
    while (total < REQ_TOTAL) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 120);
        case ($urandom_range(2))
          0: ins_pct = 85;
          1: ins_pct = 15;
          default: ins_pct = 50;
        endcase
      end
      act = ($urandom_range(99) < ins_pct) ? ihp_pkg::ACT_INSERT : ihp_pkg::ACT_DELETE;
      add_req(act, KEY_W'($urandom), pick_value(), total % 300 == 0);
      phase_left--;
      total++;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Checked mid-cycle so that the driver's updates from the last edge are visible.
    while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0)
      @(negedge clk);
    repeat (64) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### indexed_min_heap.f
rtl/core/ihp_pkg.sv
rtl/core/indexed_min_heap.sv
sim/indexed_min_heap_tb.sv
